/* rtl/sfr_pkg.sv */
// ============================================================================
// sfr_pkg: shared types and constants of the supervision frame receiver
// Command, status and register index codes, frame bytes and the
// configuration record passed from the register file to the frame engine.
// ============================================================================
`default_nettype none

package sfr_pkg;

    // Width of the timeout tick counter.
    localparam int TIMER_WIDTH = 16;
    // Width of the timeout register.
    localparam int TIMEOUT_W   = 16;
    // Width used when comparing the counter against the timeout.
    localparam int CMP_W       = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

    // Configuration port geometry.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXP_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_CTRL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_BIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;

    // Register reset values.
    localparam logic [7:0]           RST_EXP_ADDR = 8'h03;
    localparam logic [7:0]           RST_EXP_CTRL = 8'h07;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT  = 16'd3;

    // Request commands.
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_EXPECTED = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // Frame bytes and control codes.
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] CTRL_UA    = 8'h07;
    localparam logic [7:0] CTRL_DISC  = 8'h0B;
    localparam logic [7:0] CTRL_RR1   = 8'b0000_0101;
    localparam logic [7:0] CTRL_RR0   = 8'b1000_0101;
    localparam logic [7:0] CTRL_REJ1  = 8'b0000_0001;
    localparam logic [7:0] CTRL_REJ0  = 8'b1000_0001;

    // Configuration record.
    typedef struct packed {
        logic [7:0]           exp_addr;
        logic [7:0]           exp_ctrl;
        logic                 role;
        logic                 seq_bit;
        logic [TIMEOUT_W-1:0] timeout;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/sfr_req_if.sv */
// ============================================================================
// sfr_req_if: request channel of the supervision frame receiver
// Valid/ready channel carrying a command and a received line byte.
// ============================================================================
`default_nettype none

interface sfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/sfr_rsp_if.sv */
// ============================================================================
// sfr_rsp_if: result channel of the supervision frame receiver
// Valid/ready channel carrying the status and the received control byte.
// ============================================================================
`default_nettype none

interface sfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] received_control;

    modport source (output valid, output status, output received_control, input ready);
    modport sink   (input valid, input status, input received_control, output ready);
endinterface

`default_nettype wire

/* rtl/sfr_cfg_regs.sv */
// ============================================================================
// sfr_cfg_regs: configuration registers
// Decodes writes on the plain write port into the five setting registers.
// ============================================================================
`default_nettype none

module sfr_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output sfr_pkg::t_cfg                     o_cfg
);

    sfr_pkg::t_cfg r_cfg;
    sfr_pkg::t_cfg n_cfg;

    // Write decode: an index beyond the list changes nothing.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sfr_pkg::REG_EXP_ADDR: n_cfg.exp_addr = i_cfg_wdata[7:0];
                sfr_pkg::REG_EXP_CTRL: n_cfg.exp_ctrl = i_cfg_wdata[7:0];
                sfr_pkg::REG_ROLE:     n_cfg.role     = i_cfg_wdata[0];
                sfr_pkg::REG_SEQ_BIT:  n_cfg.seq_bit  = i_cfg_wdata[0];
                sfr_pkg::REG_TIMEOUT:  n_cfg.timeout  = i_cfg_wdata[sfr_pkg::TIMEOUT_W-1:0];
                default:               n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_addr <= sfr_pkg::RST_EXP_ADDR;
            r_cfg.exp_ctrl <= sfr_pkg::RST_EXP_CTRL;
            r_cfg.role     <= 1'b0;
            r_cfg.seq_bit  <= 1'b0;
            r_cfg.timeout  <= sfr_pkg::RST_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/sfr_frame_engine.sv */
// ============================================================================
// sfr_frame_engine: frame recognition state machine and result register
// Takes one request per cycle unless a result waits, updates the frame phase and
// timeout timer, and places one result in the output register for every request.
// ============================================================================
`default_nettype none

module sfr_frame_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfr_pkg::t_cfg i_cfg,
    sfr_req_if.sink            i_req,
    sfr_rsp_if.source          o_rsp
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_CHECK
    } t_phase;

    localparam logic [sfr_pkg::TIMER_WIDTH-1:0] CNT_MAX = '1;

    t_phase                          r_phase,  n_phase;
    logic [1:0]                      r_kind,   n_kind;
    logic [7:0]                      r_ctrl_seen, n_ctrl_seen;
    logic [sfr_pkg::TIMER_WIDTH-1:0] r_ticks,  n_ticks;
    logic                            r_armed,  n_armed;
    logic                            r_out_valid;
    logic [2:0]                      r_status, n_status;
    logic [7:0]                      r_rx_ctrl, n_rx_ctrl;

    logic                            accept;
    logic [7:0]                      ready_code;
    logic [7:0]                      reject_code;
    t_phase                          miss_phase;
    logic [sfr_pkg::CMP_W-1:0]       limit;
    logic [sfr_pkg::CMP_W-1:0]       timeout_ext;
    logic [sfr_pkg::CMP_W-1:0]       max_ext;
    logic [sfr_pkg::TIMER_WIDTH-1:0] ticks_inc;

    // The output register frees up whenever its result is taken.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // Receiver-ready and reject codes follow the sequence bit.
    assign ready_code  = i_cfg.seq_bit ? sfr_pkg::CTRL_RR1  : sfr_pkg::CTRL_RR0;
    assign reject_code = i_cfg.seq_bit ? sfr_pkg::CTRL_REJ1 : sfr_pkg::CTRL_REJ0;
    assign miss_phase  = (i_req.rx_byte == sfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;

    // Timeout limit is the register value clipped to the counter maximum.
    assign timeout_ext = sfr_pkg::CMP_W'(i_cfg.timeout);
    assign max_ext     = sfr_pkg::CMP_W'(CNT_MAX);
    assign limit       = (timeout_ext > max_ext) ? max_ext : timeout_ext;
    assign ticks_inc   = (r_ticks != CNT_MAX) ? r_ticks + 1'b1 : r_ticks;

    // Next state and result for the current request.
    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_ctrl_seen = r_ctrl_seen;
        n_ticks     = r_ticks;
        n_armed     = r_armed;
        n_status    = sfr_pkg::ST_PENDING;
        n_rx_ctrl   = 8'h00;

        case (i_req.cmd)
            sfr_pkg::CMD_BYTE: begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_req.rx_byte == sfr_pkg::FLAG_BYTE) begin
                            n_phase = PH_FLAG;
                        end
                    end
                    PH_FLAG: begin
                        if (i_req.rx_byte == i_cfg.exp_addr) begin
                            n_phase = PH_ADDR;
                        end else if (i_req.rx_byte != sfr_pkg::FLAG_BYTE) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_ADDR: begin
                        n_ctrl_seen = i_req.rx_byte;
                        // A reject is taken only while receiver ready is awaited.
                        if (i_req.rx_byte == ready_code) begin
                            if (i_req.rx_byte == i_cfg.exp_ctrl) begin
                                n_phase = PH_CTRL;
                                n_kind  = sfr_pkg::ST_READY[1:0];
                            end else begin
                                n_phase = miss_phase;
                            end
                        end else if (i_req.rx_byte == reject_code) begin
                            if (ready_code == i_cfg.exp_ctrl) begin
                                n_phase = PH_CTRL;
                                n_kind  = sfr_pkg::ST_REJECT[1:0];
                            end else begin
                                n_phase = miss_phase;
                            end
                        end else if (i_req.rx_byte == i_cfg.exp_ctrl) begin
                            n_phase = PH_CTRL;
                            n_kind  = sfr_pkg::ST_EXPECTED[1:0];
                        end else begin
                            n_phase = miss_phase;
                        end
                    end
                    PH_CTRL: begin
                        if (i_req.rx_byte == (i_cfg.exp_addr ^ r_ctrl_seen)) begin
                            n_phase = PH_CHECK;
                        end else begin
                            n_phase = miss_phase;
                        end
                    end
                    PH_CHECK: begin
                        if (i_req.rx_byte == sfr_pkg::FLAG_BYTE) begin
                            n_status  = {1'b0, r_kind};
                            n_rx_ctrl = r_ctrl_seen;
                            n_armed   = 1'b0;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            sfr_pkg::CMD_TICK: begin
                if (r_armed) begin
                    n_ticks = ticks_inc;
                    if (sfr_pkg::CMP_W'(ticks_inc) >= limit) begin
                        n_armed  = 1'b0;
                        n_phase  = PH_IDLE;
                        n_status = sfr_pkg::ST_TIMEOUT;
                    end
                end
            end
            sfr_pkg::CMD_RESTART: begin
                n_phase = PH_HUNT;
                n_ticks = '0;
                n_armed = !i_cfg.role &&
                          ((i_cfg.exp_ctrl == sfr_pkg::CTRL_UA) ||
                           (i_cfg.exp_ctrl == sfr_pkg::CTRL_DISC));
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // State and result registers; state moves only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= '0;
            r_ctrl_seen <= '0;
            r_ticks     <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_ctrl_seen <= n_ctrl_seen;
                r_ticks     <= n_ticks;
                r_armed     <= n_armed;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status  <= n_status;
            r_rx_ctrl <= n_rx_ctrl;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.received_control = r_rx_ctrl;

endmodule

`default_nettype wire

/* rtl/supervision_frame_receiver.sv */
// Output: a result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits untaken; the output
// register refills in the same cycle the waiting one is taken; both sides can stream.
// Reset: synchronous, active low; clears the frame phase, timer and output
// valid, and loads the register reset values. No clearing pass is needed.
// ============================================================================
// supervision_frame_receiver: supervisory frame receiver top level
// Joins the configuration registers to the frame recognition engine.
// ============================================================================
`default_nettype none

module supervision_frame_receiver (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    sfr_req_if.sink                             i_req,
    sfr_rsp_if.source                           o_rsp
);

    sfr_pkg::t_cfg cfg;

    // Setting registers.
    sfr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Frame recognition and result register.
    sfr_frame_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ============================================================================
// tb_top: testbench of the supervision frame receiver
// Drives command and byte requests into the receiver and checks every result
// against a cycle-free prediction of the frame recognizer, its timeout and its
// configuration. Directed tests cover idle behavior, frame completion, the
// timeout, reject recognition and flag recovery. Random traffic then sweeps
// several register settings with mostly well-formed frames. Both channel
// sides idle and stall at random.
// ============================================================================
`default_nettype none

module tb_top;

    // The command field has one code that the receiver does not use.
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         RANDOM_REQUESTS = 1350;
    localparam int         LONG_TIMEOUT    = 200;
    localparam int         MAX_REPORTS     = 100;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_HUNT,
        RX_FLAG,
        RX_ADDR,
        RX_CTRL,
        RX_CHECK
    } t_rx_phase;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] control;
    } t_frame_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    sfr_req_if req_if ();
    sfr_rsp_if rsp_if ();

    supervision_frame_receiver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Predicted receiver state and register copy.
    sfr_pkg::t_cfg cfg_shadow;
    t_rx_phase     rx_phase;
    logic [2:0]    kind_seen;
    logic [7:0]    ctrl_seen;
    int unsigned   tick_count;
    logic          timer_armed;

    // Results predicted but not yet delivered, oldest first.
    t_frame_result awaited_results[$];

    int unsigned   error_count     = 0;
    int unsigned   request_count   = 0;
    int unsigned   effective_count = 0;
    int unsigned   setting_count   = 0;
    int unsigned   status_seen [0:4] = '{default: 0};
    int unsigned   burst_left      = 0;
    bit            gaps_on         = 1'b1;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the receiver hangs.
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Print one line per mismatch (up to a cap) and count it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
    endtask

    // Advance the predicted receiver by one request and return its result.
    // The effective flag is cleared for requests that the receiver ignores.
    task automatic advance_receiver(input logic [1:0] cmd, input logic [7:0] b,
                                    output t_frame_result res, output bit effective);
        logic [7:0]  rr_code;
        logic [7:0]  rej_code;
        t_rx_phase   miss;
        int unsigned count_max;
        int unsigned limit;

        res       = '{status: sfr_pkg::ST_PENDING, control: 8'h00};
        effective = 1'b1;
        rr_code   = cfg_shadow.seq_bit ? sfr_pkg::CTRL_RR1 : sfr_pkg::CTRL_RR0;
        rej_code  = cfg_shadow.seq_bit ? sfr_pkg::CTRL_REJ1 : sfr_pkg::CTRL_REJ0;
        miss      = (b == sfr_pkg::FLAG_BYTE) ? RX_FLAG : RX_HUNT;
        count_max = 32'((64'd1 << sfr_pkg::TIMER_WIDTH) - 64'd1);

        case (cmd)
            sfr_pkg::CMD_BYTE: begin
                case (rx_phase)
                    RX_HUNT: begin
                        if (b == sfr_pkg::FLAG_BYTE) rx_phase = RX_FLAG;
                    end
                    RX_FLAG: begin
                        if (b == cfg_shadow.exp_addr) rx_phase = RX_ADDR;
                        else if (b != sfr_pkg::FLAG_BYTE) rx_phase = RX_HUNT;
                    end
                    RX_ADDR: begin
                        ctrl_seen = b;
                        // Ready is reported only when awaited; a reject is
                        // accepted whenever ready is the awaited code.
                        if (b == rr_code) begin
                            if (b == cfg_shadow.exp_ctrl) begin
                                rx_phase  = RX_CTRL;
                                kind_seen = sfr_pkg::ST_READY;
                            end else begin
                                rx_phase = miss;
                            end
                        end else if (b == rej_code) begin
                            if (rr_code == cfg_shadow.exp_ctrl) begin
                                rx_phase  = RX_CTRL;
                                kind_seen = sfr_pkg::ST_REJECT;
                            end else begin
                                rx_phase = miss;
                            end
                        end else if (b == cfg_shadow.exp_ctrl) begin
                            rx_phase  = RX_CTRL;
                            kind_seen = sfr_pkg::ST_EXPECTED;
                        end else begin
                            rx_phase = miss;
                        end
                    end
                    RX_CTRL: begin
                        if (b == (cfg_shadow.exp_addr ^ ctrl_seen)) rx_phase = RX_CHECK;
                        else rx_phase = miss;
                    end
                    RX_CHECK: begin
                        if (b == sfr_pkg::FLAG_BYTE) begin
                            res.status  = kind_seen;
                            res.control = ctrl_seen;
                            timer_armed = 1'b0;
                            rx_phase    = RX_IDLE;
                        end else begin
                            rx_phase = RX_HUNT;
                        end
                    end
                    default: begin
                        effective = 1'b0;
                    end
                endcase
            end
            sfr_pkg::CMD_TICK: begin
                if (timer_armed) begin
                    limit = 32'(cfg_shadow.timeout);
                    if (limit > count_max) limit = count_max;
                    if (tick_count < count_max) tick_count++;
                    if (tick_count >= limit) begin
                        timer_armed = 1'b0;
                        rx_phase    = RX_IDLE;
                        res.status  = sfr_pkg::ST_TIMEOUT;
                    end
                end else begin
                    effective = 1'b0;
                end
            end
            sfr_pkg::CMD_RESTART: begin
                rx_phase    = RX_HUNT;
                tick_count  = 0;
                timer_armed = (cfg_shadow.role == 1'b0) &&
                              (cfg_shadow.exp_ctrl == sfr_pkg::CTRL_UA ||
                               cfg_shadow.exp_ctrl == sfr_pkg::CTRL_DISC);
            end
            default: begin
                effective = 1'b0;
            end
        endcase
    endtask

    // Send one request, with a random gap between bursts, and record its
    // predicted result once it is accepted.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
        int unsigned   gap;
        t_frame_result res;
        bit            effective;

        @(negedge i_clk);
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20)
                                                  : $urandom_range(1, 3);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= cmd;
        req_if.rx_byte <= b;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        advance_receiver(cmd, b, res, effective);
        awaited_results.push_back(res);
        request_count++;
        if (effective) effective_count++;
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic quiesce();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // One register write on the configuration port.
    task automatic write_register(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sfr_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sfr_pkg::REG_EXP_ADDR: cfg_shadow.exp_addr = value[7:0];
            sfr_pkg::REG_EXP_CTRL: cfg_shadow.exp_ctrl = value[7:0];
            sfr_pkg::REG_ROLE:     cfg_shadow.role     = value[0];
            sfr_pkg::REG_SEQ_BIT:  cfg_shadow.seq_bit  = value[0];
            sfr_pkg::REG_TIMEOUT:  cfg_shadow.timeout  = value[sfr_pkg::TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    // Load a full register setting while the receiver is idle.
    task automatic apply_settings(input logic [7:0] addr, input logic [7:0] ctrl,
                                  input logic role, input logic seq_bit,
                                  input logic [15:0] timeout);
        quiesce();
        write_register(sfr_pkg::REG_EXP_ADDR, sfr_pkg::CFG_DATA_W'(addr));
        write_register(sfr_pkg::REG_EXP_CTRL, sfr_pkg::CFG_DATA_W'(ctrl));
        write_register(sfr_pkg::REG_ROLE, sfr_pkg::CFG_DATA_W'(role));
        write_register(sfr_pkg::REG_SEQ_BIT, sfr_pkg::CFG_DATA_W'(seq_bit));
        write_register(sfr_pkg::REG_TIMEOUT, sfr_pkg::CFG_DATA_W'(timeout));
        setting_count++;
    endtask

    // A byte before any restart, an unarmed tick and the unused command.
    task automatic test_idle_requests();
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::FLAG_BYTE);
        send_request(sfr_pkg::CMD_TICK, 8'h00);
        send_request(CMD_UNUSED, 8'hFF);
    endtask

    // A complete awaited frame, then a timeout on the third tick, both with
    // the reset register values.
    task automatic test_directed_frames();
        send_request(sfr_pkg::CMD_RESTART, 8'h00);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::FLAG_BYTE);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::RST_EXP_ADDR);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::RST_EXP_CTRL);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::RST_EXP_ADDR ^ sfr_pkg::RST_EXP_CTRL);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::FLAG_BYTE);
        send_request(sfr_pkg::CMD_RESTART, 8'h00);
        repeat (3) send_request(sfr_pkg::CMD_TICK, 8'h00);
    endtask

    // Awaiting receiver ready: a flag in the control slot restarts the frame,
    // and the reject frame that follows is reported as a reject.
    task automatic test_ready_and_reject();
        apply_settings(sfr_pkg::RST_EXP_ADDR, sfr_pkg::CTRL_RR0, 1'b0, 1'b0,
                       sfr_pkg::RST_TIMEOUT);
        send_request(sfr_pkg::CMD_RESTART, 8'h00);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::FLAG_BYTE);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::RST_EXP_ADDR);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::FLAG_BYTE);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::RST_EXP_ADDR);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::CTRL_REJ0);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::RST_EXP_ADDR ^ sfr_pkg::CTRL_REJ0);
        send_request(sfr_pkg::CMD_BYTE, sfr_pkg::FLAG_BYTE);
    endtask

    // A long timeout: the timer must fire exactly on its last tick.
    task automatic test_long_timeout();
        apply_settings(8'($urandom), sfr_pkg::CTRL_DISC, 1'b0, 1'b1, 16'(LONG_TIMEOUT));
        gaps_on = 1'b0;
        send_request(sfr_pkg::CMD_RESTART, 8'($urandom));
        repeat (LONG_TIMEOUT) send_request(sfr_pkg::CMD_TICK, 8'($urandom));
        gaps_on = 1'b1;
    endtask

    // Random traffic over a series of register settings: mostly restarts
    // followed by frames with random content and occasional corruption,
    // with tick runs and noise mixed in.
    task automatic test_random_traffic();
        int unsigned phase_end;
        int unsigned action;
        int unsigned n;
        int unsigned pos;
        int unsigned k;
        logic [7:0]  frame [5];
        logic [7:0]  ctl;
        logic [7:0]  addr;
        logic [7:0]  rr_code;
        logic [7:0]  rej_code;
        logic [15:0] tmo;

        phase_end = 0;
        k         = 0;
        while (request_count < RANDOM_REQUESTS) begin
            // Move to the next register setting; the first ones are extremes.
            if (k == 0 || request_count >= phase_end) begin
                tmo = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
                case (k)
                    0: apply_settings(8'h00, sfr_pkg::CTRL_UA, 1'b0, 1'b0, 16'd1);
                    1: apply_settings(8'hFF, sfr_pkg::CTRL_DISC, 1'b0, 1'b1, 16'd5);
                    2: apply_settings(sfr_pkg::FLAG_BYTE, sfr_pkg::CTRL_RR0, 1'b0, 1'b0,
                                      16'd2);
                    3: apply_settings(8'($urandom), sfr_pkg::CTRL_RR1, 1'b1, 1'b1, 16'hFFFF);
                    4: apply_settings(8'($urandom), sfr_pkg::CTRL_REJ0, 1'b0, 1'b0, 16'd3);
                    5: apply_settings(8'($urandom), 8'h00, 1'b1, 1'b0, 16'd4);
                    6: apply_settings(8'($urandom), 8'hFF, 1'b0, 1'b1, 16'd1);
                    7: apply_settings(8'($urandom), sfr_pkg::CTRL_UA, 1'b1, 1'($urandom),
                                      tmo);
                    default: begin
                        case ($urandom_range(0, 6))
                            0: ctl = sfr_pkg::CTRL_UA;
                            1: ctl = sfr_pkg::CTRL_DISC;
                            2: ctl = sfr_pkg::CTRL_RR0;
                            3: ctl = sfr_pkg::CTRL_RR1;
                            4: ctl = sfr_pkg::CTRL_REJ1;
                            5: ctl = sfr_pkg::FLAG_BYTE;
                            default: ctl = 8'($urandom);
                        endcase
                        apply_settings(8'($urandom), ctl, 1'($urandom), 1'($urandom), tmo);
                    end
                endcase
                gaps_on   = ($urandom_range(0, 3) != 0);
                phase_end = request_count + $urandom_range(120, 200);
                k++;
            end

            action = $urandom_range(0, 99);
            if (action < 70) begin
                // A frame, usually after a restart, sometimes after junk.
                if ($urandom_range(0, 9) != 0) begin
                    send_request(sfr_pkg::CMD_RESTART, 8'($urandom));
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_request(sfr_pkg::CMD_BYTE,
                                 $urandom_range(0, 1) ? sfr_pkg::FLAG_BYTE : 8'($urandom));
                end
                rr_code  = cfg_shadow.seq_bit ? sfr_pkg::CTRL_RR1 : sfr_pkg::CTRL_RR0;
                rej_code = cfg_shadow.seq_bit ? sfr_pkg::CTRL_REJ1 : sfr_pkg::CTRL_REJ0;
                case ($urandom_range(0, 5))
                    0, 1: ctl = cfg_shadow.exp_ctrl;
                    2:    ctl = rr_code;
                    3:    ctl = rej_code;
                    4:    ctl = cfg_shadow.seq_bit ? sfr_pkg::CTRL_REJ0 : sfr_pkg::CTRL_REJ1;
                    default: ctl = 8'($urandom);
                endcase
                addr = ($urandom_range(0, 9) != 0) ? cfg_shadow.exp_addr : 8'($urandom);
                frame[0] = sfr_pkg::FLAG_BYTE;
                frame[1] = addr;
                frame[2] = ctl;
                frame[3] = addr ^ ctl;
                frame[4] = sfr_pkg::FLAG_BYTE;
                if ($urandom_range(0, 3) == 0) begin
                    pos = $urandom_range(0, 4);
                    case ($urandom_range(0, 2))
                        0: frame[pos] = sfr_pkg::FLAG_BYTE;
                        1: frame[pos] = 8'($urandom);
                        default: frame[pos] = frame[pos] ^ (8'd1 << $urandom_range(0, 7));
                    endcase
                end
                for (int i = 0; i < 5; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_request(sfr_pkg::CMD_TICK, 8'($urandom));
                    end
                    send_request(sfr_pkg::CMD_BYTE, frame[i]);
                end
            end else if (action < 85) begin
                // A run of ticks, long enough to reach small timeouts.
                if ($urandom_range(0, 1) != 0) begin
                    send_request(sfr_pkg::CMD_RESTART, 8'($urandom));
                end
                n = (cfg_shadow.timeout <= 8) ? $urandom_range(1, cfg_shadow.timeout + 2)
                                              : $urandom_range(1, 8);
                repeat (n) send_request(sfr_pkg::CMD_TICK, 8'($urandom));
            end else begin
                // Noise over every command code.
                repeat ($urandom_range(1, 6)) begin
                    send_request(2'($urandom_range(0, 3)), 8'($urandom));
                end
            end
        end
    endtask

    // Result checker: compare each delivered result with the oldest prediction.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(rsp_if.status),
                                32'(sfr_pkg::ST_PENDING));
            end else begin
                want = awaited_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                end
                if (rsp_if.received_control !== want.control) begin
                    report_mismatch("received_control", 32'(rsp_if.received_control),
                                    32'(want.control));
                end
                if (want.status <= sfr_pkg::ST_TIMEOUT) status_seen[want.status]++;
            end
        end
    end

    // Result side: the ready pattern periodically changes to a randomly chosen mode.
    initial begin
        int unsigned mode;
        int unsigned cyc;
        rsp_if.ready = 1'b0;
        mode = 0;
        cyc  = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 48 == 0) mode = $urandom_range(0, 4);
            case (mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= (cyc % 4 != 3);
                2: rsp_if.ready <= 1'($urandom);
                3: rsp_if.ready <= (cyc % 3 == 0);
                default: rsp_if.ready <= (cyc % 16 < 10);
            endcase
            cyc++;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        req_if.valid   = 1'b0;
        req_if.cmd     = sfr_pkg::CMD_BYTE;
        req_if.rx_byte = 8'h00;

        cfg_shadow.exp_addr = sfr_pkg::RST_EXP_ADDR;
        cfg_shadow.exp_ctrl = sfr_pkg::RST_EXP_CTRL;
        cfg_shadow.role     = 1'b0;
        cfg_shadow.seq_bit  = 1'b0;
        cfg_shadow.timeout  = sfr_pkg::RST_TIMEOUT;
        rx_phase    = RX_IDLE;
        kind_seen   = sfr_pkg::ST_PENDING;
        ctrl_seen   = 8'h00;
        tick_count  = 0;
        timer_armed = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_requests();
        test_directed_frames();
        test_ready_and_reject();
        test_long_timeout();
        test_random_traffic();

        // Drain, then give a stray result time to show up.
        quiesce();
        repeat (8) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            report_mismatch("results never delivered", 0, 32'(awaited_results.size()));
        end

        $display("Sent %0d requests (%0d changed the receiver) over %0d register settings.",
                 request_count, effective_count, setting_count + 1);
        $display("Checked %0d awaited, %0d ready, %0d reject, %0d timeout results; %0d errors.",
                 status_seen[sfr_pkg::ST_EXPECTED], status_seen[sfr_pkg::ST_READY],
                 status_seen[sfr_pkg::ST_REJECT], status_seen[sfr_pkg::ST_TIMEOUT],
                 error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* supervision_frame_receiver.f */
rtl/sfr_pkg.sv
rtl/sfr_req_if.sv
rtl/sfr_rsp_if.sv
rtl/sfr_cfg_regs.sv
rtl/sfr_frame_engine.sv
rtl/supervision_frame_receiver.sv
dv/tb_top.sv
